### hw/rtl/sm3_pkg.sv
// Package for the SM3 hash engine: constants, word queue type and hash functions.
// Used by the front, queue, back and top modules in hw/rtl; depends on nothing.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [31:0] IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [31:0] data;
        logic        eob;
        logic        fin;
    } t_qword;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

### hw/rtl/sm3_front.sv
// Front part: packs message bytes into words, counts bytes and appends the padding.
// Depends on sm3_pkg; feeds the word queue.
module sm3_front
    import sm3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_qword     o_q_word
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_PAD   = 5'b00010,
        F_ZERO  = 5'b00100,
        F_LENHI = 5'b01000,
        F_LENLO = 5'b10000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [63:0] r_cnt, n_cnt;
    logic [23:0] r_word, n_word;
    logic [3:0]  r_wpos, n_wpos;
    logic [63:0] bits;
    logic        acc;

    assign bits   = {r_cnt[60:0], 3'b000};
    assign o_full = (r_state != F_IDLE) || i_q_full;
    assign acc    = i_push && !o_full;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_word   = r_word;
        n_wpos   = r_wpos;
        o_q_push = 1'b0;
        o_q_word = '{data: 32'h0, eob: (r_wpos == 4'd15), fin: 1'b0};
        unique case (r_state)
            F_IDLE: begin
                if (acc) begin
                    if (i_byte_valid) begin
                        n_cnt  = r_cnt + 64'd1;
                        n_word = {r_word[15:0], i_data_byte};
                        if (r_cnt[1:0] == 2'd3) begin
                            o_q_push = 1'b1;
                            o_q_word = '{data: {r_word, i_data_byte},
                                         eob: (r_cnt[5:2] == 4'd15), fin: 1'b0};
                        end
                    end
                    if (i_last) begin
                        n_state = F_PAD;
                        n_wpos  = n_cnt[5:2];
                    end
                end
            end
            F_PAD, F_ZERO: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    if (r_state == F_PAD) begin
                        unique case (r_cnt[1:0])
                            2'd0: o_q_word.data = {PAD_BYTE, 24'h0};
                            2'd1: o_q_word.data = {r_word[7:0], PAD_BYTE, 16'h0};
                            2'd2: o_q_word.data = {r_word[15:0], PAD_BYTE, 8'h0};
                            default: o_q_word.data = {r_word, PAD_BYTE};
                        endcase
                    end
                    n_wpos  = r_wpos + 4'd1;
                    n_state = (n_wpos == 4'd14) ? F_LENHI : F_ZERO;
                end
            end
            F_LENHI: begin
                if (!i_q_full) begin
                    o_q_push      = 1'b1;
                    o_q_word.data = bits[63:32];
                    n_state       = F_LENLO;
                end
            end
            F_LENLO: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    o_q_word = '{data: bits[31:0], eob: 1'b1, fin: 1'b1};
                    n_cnt    = 64'd0;
                    n_state  = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 64'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_word <= n_word;
        r_wpos <= n_wpos;
    end

endmodule

### hw/rtl/sm3_fifo.sv
// Short word queue between the front and back parts.
// Depends on sm3_pkg for the entry type and depth.
module sm3_fifo
    import sm3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qword i_word,
    output logic   o_full,
    input  logic   i_pop,
    output t_qword o_word,
    output logic   o_empty
);

    t_qword         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_word  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

### hw/rtl/sm3_back.sv
// Back part: message expansion window, 64-round compression and digest output.
// Depends on sm3_pkg; drains the word queue.
module sm3_back
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qword      i_q_word,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    typedef enum logic [2:0] {
        B_LOAD = 3'b001,
        B_RND  = 3'b010,
        B_OUT  = 3'b100
    } t_bstate;

    t_bstate     r_state;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_s [8];
    logic [31:0] n_s [8];
    logic [5:0]  r_j;
    logic        r_fin;
    logic [2:0]  r_oidx;
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, wnew;
    logic        early;

    assign early = (r_j < 6'd16);

    always_comb begin
        tj   = early ? T_LOW : T_HIGH;
        a12  = rotl(r_s[0], 5'd12);
        ss1  = rotl(a12 + r_s[4] + rotl(tj, r_j[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        ff   = early ? (r_s[0] ^ r_s[1] ^ r_s[2])
                     : ((r_s[0] & r_s[1]) | (r_s[0] & r_s[2]) | (r_s[1] & r_s[2]));
        gg   = early ? (r_s[4] ^ r_s[5] ^ r_s[6])
                     : ((r_s[4] & r_s[5]) | (~r_s[4] & r_s[6]));
        tt1  = ff + r_s[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2  = gg + r_s[7] + ss1 + r_w[0];
        n_s[0] = tt1;
        n_s[1] = r_s[0];
        n_s[2] = rotl(r_s[1], 5'd9);
        n_s[3] = r_s[2];
        n_s[4] = perm0(tt2);
        n_s[5] = r_s[4];
        n_s[6] = rotl(r_s[5], 5'd19);
        n_s[7] = r_s[6];
        wnew = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
               ^ rotl(r_w[3], 5'd7) ^ r_w[10];
    end

    assign o_q_pop       = (r_state == B_LOAD) && !i_q_empty;
    assign o_empty       = (r_state != B_OUT);
    assign o_digest_word = r_v[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (o_q_pop || r_state == B_RND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= o_q_pop ? i_q_word.data : wnew;
        end
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            r_v     <= IV;
            r_fin   <= 1'b0;
            r_oidx  <= 3'd0;
            r_j     <= 6'd0;
        end else begin
            unique case (r_state)
                B_LOAD: begin
                    if (o_q_pop && i_q_word.eob) begin
                        r_fin   <= i_q_word.fin;
                        r_s     <= r_v;
                        r_j     <= 6'd0;
                        r_state <= B_RND;
                    end
                end
                B_RND: begin
                    r_s <= n_s;
                    r_j <= r_j + 6'd1;
                    if (r_j == 6'd63) begin
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_v[i] ^ n_s[i];
                        end
                        r_oidx  <= 3'd0;
                        r_state <= r_fin ? B_OUT : B_LOAD;
                    end
                end
                B_OUT: begin
                    if (i_pop) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_v     <= IV;
                            r_state <= B_LOAD;
                        end
                    end
                end
                default: r_state <= B_LOAD;
            endcase
        end
    end

endmodule

### hw/rtl/sm3_hash_engine.sv
// SM3 hash engine top level: a byte front end, a word queue and the compression back end.
// The back end loads a block word by word, then runs 64 rounds at one per cycle. During the
// rounds the queue holds only 16 bytes, so a steady sender is stalled once it fills.
// After a last item the input is held off while the padding and the length are pushed, then
// each padded block takes 16 word loads and 64 rounds, before eight words show one per pop.
// Synchronous active-low reset restores the initial value and clears the byte, queue, round and output counts.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_qword fq_word, qb_word;
    logic   fq_push, q_full, q_pop, q_empty;

    sm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_q_full     (q_full),
        .o_q_push     (fq_push),
        .o_q_word     (fq_word)
    );

    sm3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_word  (fq_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_word  (qb_word),
        .o_empty (q_empty)
    );

    sm3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_word      (qb_word),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

### hw/rtl/sm3_checker.sv
// Port-level checker for the SM3 hash engine, bound to the top level.
// Depends only on the top level's ports.
module sm3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag does not match the index");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_word) |=>
            (!o_empty && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest words not delivered in order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_digest_word)))
        else $error("waiting digest word changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_word) |=> o_empty)
        else $error("digest continues after the last word");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
